// ===== rtl/wsc_pkg.sv =====
// shared types and constants for the waypoint steering controller
`timescale 1ns / 1ps
package wsc_pkg;
	localparam int PATH_DEPTH_DEF   = 16;
	localparam int CORDIC_ITERS_DEF = 14;
	localparam logic [1:0] CMD_RESET  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_STEP   = 2'd2;
	localparam int PI_Q12     = 12868;
	localparam int TWO_PI_Q12 = 25736;
	localparam int HALF_PI_Q16 = 102944;
	localparam int ZW = 20;

	// controller to datapath
	typedef struct packed {
		logic load_in;    // capture item
		logic smooth;     // filter pose, arm cordic setup
		logic iterate;    // one cordic step
		logic finish;     // form result
	} wsc_cmd_t;

	typedef struct packed {
		logic last_iter;
	} wsc_stat_t;

	function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
		case (i)
			5'd0:  atan_q16 = 20'sd51472;
			5'd1:  atan_q16 = 20'sd30386;
			5'd2:  atan_q16 = 20'sd16055;
			5'd3:  atan_q16 = 20'sd8150;
			5'd4:  atan_q16 = 20'sd4091;
			5'd5:  atan_q16 = 20'sd2047;
			5'd6:  atan_q16 = 20'sd1024;
			5'd7:  atan_q16 = 20'sd512;
			5'd8:  atan_q16 = 20'sd256;
			5'd9:  atan_q16 = 20'sd128;
			5'd10: atan_q16 = 20'sd64;
			5'd11: atan_q16 = 20'sd32;
			5'd12: atan_q16 = 20'sd16;
			5'd13: atan_q16 = 20'sd8;
			5'd14: atan_q16 = 20'sd4;
			5'd15: atan_q16 = 20'sd2;
			5'd16: atan_q16 = 20'sd1;
			default: atan_q16 = 20'sd0;
		endcase
	endfunction
endpackage

// ===== rtl/waypoint_steering_controller_unit.sv =====
// top level of the waypoint steering controller
`timescale 1ns / 1ps
// a sensor step item goes from acceptance to result through smoothing, ram read and
// cordic setup, one cordic step a cycle, and finish
// s_tready is low while a step is in work, so the next step waits until it is done
// reset and append items give no result
// a result waiting on m_tready holds the next step in its finish cycle
// arst_n clears the queue, filtered pose, registers to defaults; ram unset
module waypoint_steering_controller_unit #(
	parameter int PATH_DEPTH   = wsc_pkg::PATH_DEPTH_DEF,
	parameter int CORDIC_ITERS = wsc_pkg::CORDIC_ITERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tuser,   // cmd [1:0], zero above
	// pos_x, pos_y, yaw, front_dist_mm, rear_dist_mm, left_ir_mv, right_ir_mv
	input  logic [103:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// steer, pedal, waypoint_passed, path_done, obstacle_stop
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	localparam logic [2:0] R_PEDAL = 3'd0, R_REACH = 3'd1, R_FRONT = 3'd2,
		R_OTHER = 3'd3, R_GAIN = 3'd4;

	logic [14:0] cruise_pedal_q;
	logic [11:0] reach_q, front_q, other_q;
	logic [8:0]  gain_q;
	wsc_pkg::wsc_cmd_t  cmd;
	wsc_pkg::wsc_stat_t stat;
	logic idle, in_fire;
	logic [33:0] result;
	logic [33:0] out_q;

	// config register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cruise_pedal_q <= 15'd3277; reach_q <= 12'd38;
			front_q <= 12'd150; other_q <= 12'd100; gain_q <= 9'd230;
		end else if (cfg_we) begin
			case (cfg_index)
				R_PEDAL: cruise_pedal_q <= cfg_data;
				R_REACH: reach_q <= cfg_data[11:0];
				R_FRONT: front_q <= cfg_data[11:0];
				R_OTHER: other_q <= cfg_data[11:0];
				R_GAIN:  gain_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign s_tready = idle;
	assign in_fire = s_tvalid && s_tready;

	wsc_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.in_cmd(s_tuser[1:0]), .out_busy(m_tvalid && !m_tready), .stat(stat),
		.cmd(cmd), .idle(idle));

	wsc_dp #(.PATH_DEPTH(PATH_DEPTH), .CORDIC_ITERS(CORDIC_ITERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_cmd(s_tuser[1:0]),
		.pos_x(s_tdata[15:0]), .pos_y(s_tdata[31:16]), .yaw(s_tdata[46:32]),
		.front_dist_mm(s_tdata[58:47]), .rear_dist_mm(s_tdata[70:59]),
		.left_ir_mv(s_tdata[83:71]), .right_ir_mv(s_tdata[96:84]),
		.cruise_pedal(cruise_pedal_q), .reach_tolerance(reach_q),
		.front_stop_mm(front_q), .other_stop_mm(other_q), .steer_gain(gain_q),
		.result(result));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (cmd.finish) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) out_q <= result;
	end
	assign m_tdata = {6'd0, out_q};
endmodule

// ===== rtl/wsc_ram.sv =====
// generic single-write ram with registered read
`timescale 1ns / 1ps
module wsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/wsc_ctrl.sv =====
// sequencing state machine
`timescale 1ns / 1ps
module wsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [1:0]          in_cmd,
	input  logic                out_busy,
	input  wsc_pkg::wsc_stat_t  stat,
	output wsc_pkg::wsc_cmd_t   cmd,
	output logic                idle
);
	localparam logic [2:0] S_IDLE = 3'd0, S_SMOOTH = 3'd1, S_ITER = 3'd2,
		S_FIN = 3'd3, S_WAIT = 3'd4;
	logic [2:0] state_q;

	always_comb begin
		cmd = '0;
		cmd.load_in = in_fire;
		cmd.smooth  = (state_q == S_SMOOTH);
		cmd.iterate = (state_q == S_ITER);
		cmd.finish  = (state_q == S_FIN) && !out_busy;
		idle = (state_q == S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire && in_cmd == wsc_pkg::CMD_STEP) state_q <= S_SMOOTH;
				S_SMOOTH: state_q <= S_WAIT;
				S_WAIT: state_q <= S_ITER;
				S_ITER: if (stat.last_iter) state_q <= S_FIN;
				S_FIN: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/wsc_dp.sv =====
// datapath: queue, pose filter, cordic, steering law
`timescale 1ns / 1ps
module wsc_dp #(
	parameter int PATH_DEPTH   = wsc_pkg::PATH_DEPTH_DEF,
	parameter int CORDIC_ITERS = wsc_pkg::CORDIC_ITERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wsc_pkg::wsc_cmd_t   cmd,
	output wsc_pkg::wsc_stat_t  stat,
	input  logic [1:0]          in_cmd,
	input  logic signed [15:0]  pos_x,
	input  logic signed [15:0]  pos_y,
	input  logic signed [14:0]  yaw,
	input  logic [11:0]         front_dist_mm,
	input  logic [11:0]         rear_dist_mm,
	input  logic [12:0]         left_ir_mv,
	input  logic [12:0]         right_ir_mv,
	input  logic [14:0]         cruise_pedal,
	input  logic [11:0]         reach_tolerance,
	input  logic [11:0]         front_stop_mm,
	input  logic [11:0]         other_stop_mm,
	input  logic [8:0]          steer_gain,
	output logic [33:0]         result
);
	localparam int AW = $clog2(PATH_DEPTH);
	localparam int CW = $clog2(PATH_DEPTH + 1);
	localparam int XW = 30;
	localparam int ZW = wsc_pkg::ZW;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic signed [15:0] fx_q, fy_q, fh_q;
	logic signed [15:0] px_q, py_q;
	logic signed [14:0] yaw_q;
	logic obst_q;
	logic [AW-1:0] waddr;
	logic signed [15:0] wx, wy;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [4:0] it_q;
	logic signed [16:0] dx_q, dy_q;
	logic do_append;
	logic dx_abs_lt, dy_abs_lt;

	// tail = head + count modulo depth
	always_comb begin
		logic [CW:0] t;
		t = (CW+1)'(head_q) + (CW+1)'(count_q);
		if (t >= (CW+1)'(PATH_DEPTH)) t = t - (CW+1)'(PATH_DEPTH);
		waddr = t[AW-1:0];
	end
	assign do_append = cmd.load_in && in_cmd == wsc_pkg::CMD_APPEND &&
		count_q < CW'(PATH_DEPTH);

	wsc_ram #(.WIDTH(16), .DEPTH(PATH_DEPTH)) u_ram_x (.clk(clk), .we(do_append),
		.waddr(waddr), .wdata(pos_x), .raddr(head_q), .rdata(wx));
	wsc_ram #(.WIDTH(16), .DEPTH(PATH_DEPTH)) u_ram_y (.clk(clk), .we(do_append),
		.waddr(waddr), .wdata(pos_y), .raddr(head_q), .rdata(wy));

	function automatic logic signed [15:0] smooth(input logic signed [15:0] nv,
		input logic signed [15:0] ov);
		logic signed [20:0] s;
		logic [20:0] a;
		logic [20:0] q;
		s = 21'(nv) * 21'sd7 + 21'(ov) * 21'sd3 + 21'sd5;
		a = s[20] ? 21'(-s) + 21'd9 : 21'(s);
		q = 21'((42'(a) * 42'd419431) >> 22);
		if (a - q * 21'd10 >= 21'd10) q = q + 21'd1;
		smooth = s[20] ? -16'(q) : 16'(q);
	endfunction

	// obstacle test, ir compared exactly
	function automatic logic ir_close(input logic [12:0] mv, input logic [11:0] th);
		logic signed [22:0] l;
		l = (23'sd2500 - $signed(23'(mv)) * 23'sd2) * 23'sd100;
		ir_close = l < $signed(23'(th)) * 23'sd7;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; count_q <= '0;
			fx_q <= '0; fy_q <= '0; fh_q <= '0;
		end else begin
			if (cmd.load_in && in_cmd == wsc_pkg::CMD_RESET) begin
				head_q <= '0; count_q <= '0;
				fx_q <= pos_x; fy_q <= pos_y; fh_q <= 16'(yaw);
			end
			if (do_append) count_q <= count_q + 1'b1;
			if (cmd.smooth) begin
				fx_q <= smooth(px_q, fx_q);
				fy_q <= smooth(py_q, fy_q);
				fh_q <= smooth(16'(yaw_q), fh_q);
			end
			if (cmd.finish && count_q != '0 && dx_abs_lt && dy_abs_lt) begin
				head_q <= (head_q == AW'(PATH_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q <= pos_x; py_q <= pos_y; yaw_q <= yaw;
			obst_q <= front_dist_mm < front_stop_mm || rear_dist_mm < other_stop_mm ||
				ir_close(left_ir_mv, other_stop_mm) || ir_close(right_ir_mv, other_stop_mm);
		end
	end

	// cordic: setup in the cycle after smoothing (ram read ready)
	logic setup_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) setup_q <= 1'b0;
		else setup_q <= cmd.smooth;
	end

	always_comb begin
		logic [16:0] ax, ay;
		ax = dx_q[16] ? 17'(-dx_q) : 17'(dx_q);
		ay = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);
		dx_abs_lt = ax < 17'(reach_tolerance);
		dy_abs_lt = ay < 17'(reach_tolerance);
	end

	always_ff @(posedge clk) begin
		if (setup_q) begin
			logic signed [16:0] dx, dy;
			dx = 17'(wx) - 17'(fx_q);
			dy = 17'(wy) - 17'(fy_q);
			dx_q <= dx; dy_q <= dy; it_q <= '0;
			if (dx[16]) begin
				if (!dy[16]) begin
					x_q <= XW'(dy) <<< 8; y_q <= -(XW'(dx) <<< 8);
					z_q <= ZW'(wsc_pkg::HALF_PI_Q16);
				end else begin
					x_q <= -(XW'(dy) <<< 8); y_q <= XW'(dx) <<< 8;
					z_q <= -ZW'(wsc_pkg::HALF_PI_Q16);
				end
			end else begin
				x_q <= XW'(dx) <<< 8; y_q <= XW'(dy) <<< 8; z_q <= '0;
			end
		end else if (cmd.iterate) begin
			if (y_q > 0) begin
				x_q <= x_q + (y_q >>> it_q); y_q <= y_q - (x_q >>> it_q);
				z_q <= z_q + wsc_pkg::atan_q16(it_q);
			end else begin
				x_q <= x_q - (y_q >>> it_q); y_q <= y_q + (x_q >>> it_q);
				z_q <= z_q - wsc_pkg::atan_q16(it_q);
			end
			it_q <= it_q + 1'b1;
		end
	end
	assign stat.last_iter = (it_q == 5'(CORDIC_ITERS - 1));

	// steering law, used in the finish cycle
	always_comb begin
		logic signed [ZW-1:0] zr;
		logic signed [17:0] b, err;
		logic signed [27:0] p;
		logic signed [15:0] st;
		logic [14:0] pd;
		logic passed, done;
		zr = (z_q + ZW'(8)) >>> 4;
		b = (dx_q == '0 && dy_q == '0) ? '0 : 18'(zr);
		err = b - 18'(fh_q);
		if (err > 18'sd12868) err = err - 18'(wsc_pkg::TWO_PI_Q12);
		else if (err < -18'sd12868) err = err + 18'(wsc_pkg::TWO_PI_Q12);
		p = (28'(err) * $signed({19'd0, steer_gain}) + 28'sd128) >>> 8;
		if (p > 28'sd32767) st = 16'sh7fff;
		else if (p < -28'sd32768) st = -16'sh8000;
		else st = 16'(p);
		pd = cruise_pedal; passed = 1'b0; done = 1'b0;
		if (count_q == '0) begin
			st = '0; pd = '0; done = 1'b1;
		end else if (dx_abs_lt && dy_abs_lt) begin
			st = '0; passed = 1'b1;
			if (count_q == CW'(1)) begin pd = '0; done = 1'b1; end
		end
		if (obst_q) begin st = '0; pd = '0; end
		result = {obst_q, done, passed, pd, st};
	end
endmodule

// ===== tb/waypoint_steering_controller_unit_test.sv =====
// self-checking testbench for the waypoint steering controller: a predictor,
// a randomised driver and a checking monitor
`timescale 1ns / 1ps
module waypoint_steering_controller_unit_test;
	localparam int QDEPTH = 16;
	localparam int ITERS = 14;
	localparam int DRAIN_CYCLES = 40;      // longer than one step takes without output stalls
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_ITEMS = 1350;
	localparam int NUM_PHASES = 6;

	// register indexes of the write port
	typedef enum logic [2:0] {
		REG_CRUISE_PEDAL = 3'd0,
		REG_REACH_TOL    = 3'd1,
		REG_FRONT_STOP   = 3'd2,
		REG_OTHER_STOP   = 3'd3,
		REG_STEER_GAIN   = 3'd4
	} reg_index_t;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [14:0] yaw;
		logic [11:0]        front;
		logic [11:0]        rear;
		logic [12:0]        left_mv;
		logic [12:0]        right_mv;
	} pose_item_t;

	typedef struct {
		logic signed [15:0] steer;
		logic [14:0]        pedal;
		logic               passed;
		logic               done;
		logic               obst;
	} steer_cmd_t;

	localparam longint ATAN_Q16 [20] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tuser = '0;
	logic [103:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [14:0]  cfg_data = '0;

	waypoint_steering_controller_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state: own copy of the path queue, filtered pose and registers
	logic signed [15:0] path_x [QDEPTH];
	logic signed [15:0] path_y [QDEPTH];
	int unsigned path_head = 0;
	int unsigned path_count = 0;
	longint pose_x = 0, pose_y = 0, pose_yaw = 0;
	longint r_cruise = 3277, r_tol = 38, r_front = 150, r_other = 100, r_gain = 230;

	pose_item_t pending_items [$];
	steer_cmd_t expected_cmds [$];

	int mismatches = 0;
	int cmds_checked = 0;
	int reaches_seen = 0;
	int stops_seen = 0;
	int done_seen = 0;
	int items_sent = 0;
	int unsigned cycle_count = 0;
	logic quiet = 1'b0;          // no idling on either side while high
	logic hold_req = 1'b0;       // toggled to ask the receiver for a long hold

	// low-pass filter 0.7*new + 0.3*old, rounded to nearest, upward on ties
	function automatic longint lowpass(longint nv, longint old);
		longint s;
		s = 7 * nv + 3 * old + 5;
		if (s >= 0)
			return s / 10;
		return -((-s + 9) / 10);
	endfunction

	// vectoring cordic atan2, q12 radians
	function automatic longint bearing(longint dx, longint dy);
		longint x, y, z, nx, xs, ys;
		if (dx == 0 && dy == 0)
			return 0;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		// pre-rotate the left half plane by a quarter turn
		if (dx < 0) begin
			if (dy >= 0) begin
				nx = y; y = -x; x = nx; z = wsc_pkg::HALF_PI_Q16;
			end else begin
				nx = -y; y = x; x = nx; z = -wsc_pkg::HALF_PI_Q16;
			end
		end
		for (int i = 0; i < ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z += ATAN_Q16[i];
			end else begin
				x = x - ys; y = y + xs; z -= ATAN_Q16[i];
			end
		end
		return (z + 8) >>> 4;
	endfunction

	function automatic bit ir_near(longint mv);
		return (2500 - 2 * mv) * 100 < 7 * r_other;
	endfunction

	// advance the controller model by one item; returns 1 when a command results
	function automatic bit steer_step(pose_item_t it, output steer_cmd_t res);
		longint dx, dy, err, st, ped;
		int unsigned h;
		res = '{default: '0};
		st = 0;
		ped = 0;
		case (it.cmd)
			wsc_pkg::CMD_RESET: begin
				path_head = 0;
				path_count = 0;
				pose_x = longint'(it.px);
				pose_y = longint'(it.py);
				pose_yaw = longint'(it.yaw);
				return 1'b0;
			end
			wsc_pkg::CMD_APPEND: begin
				// a full queue drops the waypoint
				if (path_count < QDEPTH) begin
					path_x[(path_head + path_count) % QDEPTH] = it.px;
					path_y[(path_head + path_count) % QDEPTH] = it.py;
					path_count++;
				end
				return 1'b0;
			end
			wsc_pkg::CMD_STEP: ;
			default: return 1'b0;
		endcase
		pose_x = lowpass(longint'(it.px), pose_x);
		pose_y = lowpass(longint'(it.py), pose_y);
		pose_yaw = lowpass(longint'(it.yaw), pose_yaw);
		if (path_count > 0) begin
			h = path_head % QDEPTH;
			dx = longint'(path_x[h]) - pose_x;
			dy = longint'(path_y[h]) - pose_y;
			err = bearing(dx, dy) - pose_yaw;
			// one wrap into plus or minus pi
			if (err > wsc_pkg::PI_Q12)
				err -= wsc_pkg::TWO_PI_Q12;
			else if (err < -wsc_pkg::PI_Q12)
				err += wsc_pkg::TWO_PI_Q12;
			st = (err * r_gain + 128) >>> 8;
			if (st > 32767) st = 32767;
			if (st < -32768) st = -32768;
			ped = r_cruise;
			// waypoint reached: pop it and hold the wheel straight
			if ((dx < 0 ? -dx : dx) < r_tol && (dy < 0 ? -dy : dy) < r_tol) begin
				path_head = (h + 1) % QDEPTH;
				path_count--;
				res.passed = 1'b1;
				st = 0;
			end
		end
		if (path_count == 0) begin
			res.done = 1'b1;
			ped = 0;
			st = 0;
		end
		if (longint'(it.front) < r_front || longint'(it.rear) < r_other ||
				ir_near(longint'(it.left_mv)) || ir_near(longint'(it.right_mv))) begin
			res.obst = 1'b1;
			ped = 0;
			st = 0;
		end
		res.steer = st[15:0];
		res.pedal = ped[14:0];
		return 1'b1;
	endfunction

	// driver: one item at a time from the pending queue, random gaps between items
	int unsigned send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		pose_item_t it;
		steer_cmd_t res;
		logic next_valid;
		int unsigned gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			next_valid = s_tvalid;
			gap = send_gap;
			if (s_tvalid && s_tready) begin
				it.cmd = s_tuser[1:0];
				{it.right_mv, it.left_mv, it.rear, it.front, it.yaw, it.py, it.px} =
					s_tdata[96:0];
				if (steer_step(it, res))
					expected_cmds.push_back(res);
				next_valid = 1'b0;
				gap = quiet ? 0 : $urandom_range(0, 10);
			end else if (!s_tvalid && gap > 0) begin
				gap = gap - 1;
			end
			// with no gap the next item is driven at the edge that accepts the last one
			if (!next_valid && gap == 0 && pending_items.size() > 0) begin
				it = pending_items[0];
				pending_items.delete(0);
				s_tuser <= {14'd0, it.cmd};
				s_tdata <= {7'd0, it.right_mv, it.left_mv, it.rear, it.front, it.yaw,
					it.py, it.px};
				next_valid = 1'b1;
			end
			send_gap <= gap;
			s_tvalid <= next_valid;
		end
	end

	// monitor: random stalls per result, plus a long hold when asked
	int unsigned recv_stall = 0;
	logic hold_seen = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		steer_cmd_t want, got;
		int unsigned d;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.steer = m_tdata[15:0];
				got.pedal = m_tdata[30:16];
				got.passed = m_tdata[31];
				got.done = m_tdata[32];
				got.obst = m_tdata[33];
				if (expected_cmds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected command steer=%0d pedal=%0d", $realtime,
							got.steer, got.pedal);
				end else begin
					want = expected_cmds[0];
					expected_cmds.delete(0);
					cmds_checked++;
					reaches_seen += int'(got.passed);
					stops_seen += int'(got.obst);
					done_seen += int'(got.done);
					if (got.steer !== want.steer || got.pedal !== want.pedal ||
							got.passed !== want.passed || got.done !== want.done ||
							got.obst !== want.obst) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: command %0d expected steer=%0d pedal=%0d pass=%b done=%b stop=%b, got steer=%0d pedal=%0d pass=%b done=%b stop=%b",
								$realtime, cmds_checked, want.steer, want.pedal, want.passed,
								want.done, want.obst, got.steer, got.pedal, got.passed,
								got.done, got.obst);
					end
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				recv_stall <= LONG_HOLD;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				d = quiet ? 0 : $urandom_range(0, 10);
				recv_stall <= (d > 0) ? d - 1 : 0;
				m_tready <= (d == 0);
			end else if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic queue_item(logic [1:0] cmd, int x, int y, int yw,
			int f, int r, int l, int rr);
		pose_item_t it;
		it.cmd = cmd;
		it.px = 16'(x);
		it.py = 16'(y);
		it.yaw = 15'(yw);
		it.front = 12'(f);
		it.rear = 12'(r);
		it.left_mv = 13'(l);
		it.right_mv = 13'(rr);
		pending_items.push_back(it);
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// sensor step with a clear road most of the time
	task automatic queue_step(int x, int y, int yw);
		if ($urandom_range(0, 9) == 0)
			queue_item(wsc_pkg::CMD_STEP, x, y, yw, $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 8191), $urandom_range(0, 8191));
		else
			queue_item(wsc_pkg::CMD_STEP, x, y, yw, $urandom_range(200, 4000),
				$urandom_range(200, 4000), $urandom_range(0, 1000), $urandom_range(0, 1000));
	endtask

	function automatic int clip16(int v);
		return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
	endfunction

	task automatic write_reg(reg_index_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[14:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CRUISE_PEDAL: r_cruise = val & 32'h7fff;
			REG_REACH_TOL:    r_tol = val & 32'hfff;
			REG_FRONT_STOP:   r_front = val & 32'hfff;
			REG_OTHER_STOP:   r_other = val & 32'hfff;
			REG_STEER_GAIN:   r_gain = val & 32'h1ff;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || s_tvalid || expected_cmds.size() != 0)
			@(posedge clk);
		// reset and append items leave no trace to wait on
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one path: pose reset, a run of waypoints, then steps that chase them
	task automatic queue_path();
		int n, wx, wy, reps, jx, jy;
		int wpx [$];
		int wpy [$];
		wx = $urandom_range(0, 16000) - 8000;
		wy = $urandom_range(0, 16000) - 8000;
		queue_item(wsc_pkg::CMD_RESET, wx, wy, $urandom_range(0, 25736) - 12868,
			0, 0, 0, 0);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			wx = clip16(wx + $urandom_range(0, 4000) - 2000);
			wy = clip16(wy + $urandom_range(0, 4000) - 2000);
			wpx.push_back(wx);
			wpy.push_back(wy);
			queue_item(wsc_pkg::CMD_APPEND, wx, wy, $urandom_range(0, 32767) - 16384,
				$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 8191),
				$urandom_range(0, 8191));
		end
		for (int i = 0; i < wpx.size() && i < 18; i++) begin
			reps = $urandom_range(1, 5);
			for (int k = 0; k < reps; k++) begin
				jx = $urandom_range(0, 60) - 30;
				jy = $urandom_range(0, 60) - 30;
				queue_step(clip16(wpx[i] + jx), clip16(wpy[i] + jy),
					$urandom_range(0, 25736) - 12868);
			end
		end
		// a step past the end of the path
		queue_step(wx, wy, $urandom_range(0, 25736) - 12868);
	endtask

	task automatic queue_noise();
		queue_item(2'($urandom_range(0, 3)), $urandom_range(0, 65535) - 32768,
			$urandom_range(0, 65535) - 32768, $urandom_range(0, 32767) - 16384,
			$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 8191),
			$urandom_range(0, 8191));
	endtask

	initial begin
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty path, extremes, atan2 of a zero vector, wrap, each stop source
		queue_step(0, 0, 0);
		queue_item(wsc_pkg::CMD_RESET, 100, 100, 0, 0, 0, 0, 0);
		queue_item(wsc_pkg::CMD_APPEND, 100, 100, 0, 0, 0, 0, 0);
		queue_step(100, 100, 0);
		queue_item(wsc_pkg::CMD_RESET, 0, 0, -12868, 0, 0, 0, 0);
		queue_item(wsc_pkg::CMD_APPEND, -32768, 10, 0, 0, 0, 0, 0);
		queue_item(wsc_pkg::CMD_APPEND, -32768, -10, 0, 0, 0, 0, 0);
		queue_item(wsc_pkg::CMD_APPEND, 32767, 32767, 0, 0, 0, 0, 0);
		queue_step(0, 0, -12868);
		queue_item(wsc_pkg::CMD_RESET, 0, 0, 12868, 0, 0, 0, 0);
		queue_step(0, 0, 12868);
		queue_item(wsc_pkg::CMD_STEP, 0, 0, 0, 0, 4000, 0, 0);
		queue_item(wsc_pkg::CMD_STEP, 0, 0, 0, 4000, 0, 0, 0);
		queue_item(wsc_pkg::CMD_STEP, 0, 0, 0, 4095, 4095, 5000, 0);
		queue_item(wsc_pkg::CMD_STEP, 0, 0, 0, 4095, 4095, 0, 5000);
		queue_item(wsc_pkg::CMD_STEP, 32767, -32768, 16383, 4095, 4095, 8191, 8191);
		queue_item(CMD_UNUSED, -1, -1, -1, 4095, 4095, 8191, 8191);
		queue_item(wsc_pkg::CMD_STEP, -32768, 32767, -16384, 4000, 4000, 0, 0);
		wait_idle();

		target = RANDOM_ITEMS / NUM_PHASES;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				1: begin
					write_reg(REG_CRUISE_PEDAL, $urandom_range(1, 32766));
					write_reg(REG_REACH_TOL, $urandom_range(20, 300));
					write_reg(REG_FRONT_STOP, $urandom_range(50, 300));
					write_reg(REG_OTHER_STOP, $urandom_range(50, 300));
					write_reg(REG_STEER_GAIN, $urandom_range(1, 510));
				end
				2: begin
					write_reg(REG_CRUISE_PEDAL, 0);
					write_reg(REG_REACH_TOL, 0);
					write_reg(REG_FRONT_STOP, 0);
					write_reg(REG_OTHER_STOP, 0);
					write_reg(REG_STEER_GAIN, 0);
				end
				3: begin
					write_reg(REG_CRUISE_PEDAL, 32767);
					write_reg(REG_REACH_TOL, 4095);
					write_reg(REG_FRONT_STOP, 4095);
					write_reg(REG_OTHER_STOP, 4095);
					write_reg(REG_STEER_GAIN, 511);
				end
				4: begin
					write_reg(REG_REACH_TOL, 2560);
					write_reg(REG_FRONT_STOP, 150);
					write_reg(REG_OTHER_STOP, 100);
					write_reg(REG_STEER_GAIN, 511);
				end
				5: begin
					write_reg(REG_CRUISE_PEDAL, $urandom_range(0, 32767));
					write_reg(REG_REACH_TOL, $urandom_range(0, 2560));
					write_reg(REG_FRONT_STOP, $urandom_range(0, 4000));
					write_reg(REG_OTHER_STOP, $urandom_range(0, 4000));
					write_reg(REG_STEER_GAIN, $urandom_range(0, 511));
				end
				default: ;
			endcase
			// one phase runs back to back with no idling
			@(negedge clk) quiet = (ph == 4);
			target = items_sent + RANDOM_ITEMS / NUM_PHASES;
			while (items_sent < target) begin
				if ($urandom_range(0, 99) < 85)
					queue_path();
				else
					repeat ($urandom_range(1, 6)) queue_noise();
				// the receiver sits out a long stretch while the sender keeps going
				if (ph == 1 && items_sent >= target - RANDOM_ITEMS / NUM_PHASES / 2 &&
						hold_seen == hold_req && recv_stall == 0 && cycle_count > 0 &&
						pending_items.size() > 20) begin
					@(negedge clk) hold_req = ~hold_req;
				end
				while (pending_items.size() > 40)
					@(posedge clk);
			end
			wait_idle();
		end

		wait_idle();
		$display("ran %0d items through %0d register settings; %0d steering commands checked",
			items_sent, NUM_PHASES, cmds_checked);
		$display("%0d waypoints reached, %0d obstacle stops, %0d with the path empty",
			reaches_seen, stops_seen, done_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
